// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TVT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled in reset
`define TVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/tvt_pkg.sv -----
// types, constants and voltage table for the thermistor voltage to temperature block
package tvt_pkg;

    localparam int TablePoints = 33;
    localparam int DefinedPoints = 33;
    localparam int VoltBits = 12;
    localparam int TempBits = 15;
    localparam int QuoBits = 9;
    localparam int RemBits = 21;
    localparam int TempStart = -4000;
    localparam int TempStep = 500;

    localparam logic [VoltBits-1:0] VoltPoints [DefinedPoints] = '{
        12'd2440, 12'd2420, 12'd2400, 12'd2380, 12'd2350, 12'd2320, 12'd2270,
        12'd2230, 12'd2170, 12'd2110, 12'd2050, 12'd1990, 12'd1920, 12'd1860,
        12'd1800, 12'd1740, 12'd1680, 12'd1630, 12'd1590, 12'd1550, 12'd1510,
        12'd1480, 12'd1450, 12'd1430, 12'd1400, 12'd1380, 12'd1370, 12'd1350,
        12'd1340, 12'd1330, 12'd1320, 12'd1310, 12'd1300
    };

    // points past the defined ones read as 0 mV
    function automatic logic [VoltBits-1:0] volt_point(input int idx);
        logic [VoltBits-1:0] v;
        v = '0;
        if (idx < DefinedPoints) begin
            v = VoltPoints[idx];
        end
        return v;
    endfunction

    typedef struct packed {
        logic                       valid;
        logic [VoltBits-1:0]        voltage;
        logic                       found;
        logic [VoltBits-1:0]        diff;
        logic [VoltBits-1:0]        span;
        logic signed [TempBits-1:0] base;
    } t_srch;

    typedef struct packed {
        logic                       valid;
        logic                       found;
        logic                       zero_span;
        logic [RemBits-1:0]         rem;
        logic [VoltBits-1:0]        span;
        logic [QuoBits-1:0]         quo;
        logic signed [TempBits-1:0] base;
    } t_div;

endpackage

// ----- hw/rtl/thermistor_voltage_to_temp_top.sv -----
// top level: thermistor voltage to temperature by table search and interpolation
// throughput: one beat per cycle; a row of TABLE_POINTS-1 search cells, one
// multiply stage and nine divider cells advance together while the output is free
// reset: synchronous active-low, clears all stage valid bits; no table clearing needed
module thermistor_voltage_to_temp_top #(
    parameter int TABLE_POINTS = tvt_pkg::TablePoints
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [11:0] voltage_mv
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [14:0] temp_centi
    output logic [0:0]  o_m_axis_tuser   // [0] out_of_range
);

    `include "assert_macros.svh"

    localparam int Segs = TABLE_POINTS - 1;
    localparam int Qb = tvt_pkg::QuoBits;
    localparam logic [tvt_pkg::VoltBits-1:0] VFirst = tvt_pkg::volt_point(0);
    localparam logic [tvt_pkg::VoltBits-1:0] VLast = tvt_pkg::volt_point(TABLE_POINTS - 1);

    logic                               w_en;
    tvt_pkg::t_srch                     w_head;
    tvt_pkg::t_srch                     w_srch [TABLE_POINTS];
    tvt_pkg::t_div                      r_mul;
    tvt_pkg::t_div                      n_mul;
    tvt_pkg::t_div                      w_div [Qb+1];
    logic                               r_out_valid;
    logic signed [tvt_pkg::TempBits-1:0] r_out_temp;
    logic                               r_out_oor;
    logic signed [tvt_pkg::TempBits-1:0] n_out_temp;

    assign w_en = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_comb begin
        w_head         = '0;
        w_head.valid   = i_s_axis_tvalid;
        w_head.voltage = i_s_axis_tdata[tvt_pkg::VoltBits-1:0];
    end

    assign w_srch[0] = w_head;

    for (genvar g = 0; g < Segs; g++) begin : g_srch
        tvt_search_cell #(
            .SegIdx(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_stage(w_srch[g]),
            .o_stage(w_srch[g+1])
        );
    end

    always_comb begin
        n_mul           = '0;
        n_mul.valid     = w_srch[Segs].valid;
        n_mul.found     = w_srch[Segs].found;
        n_mul.zero_span = (w_srch[Segs].span == '0);
        n_mul.rem       = tvt_pkg::RemBits'(w_srch[Segs].diff)
                          * tvt_pkg::RemBits'(tvt_pkg::TempStep);
        n_mul.span      = w_srch[Segs].span;
        n_mul.base      = w_srch[Segs].base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul.valid <= 1'b0;
        end else if (w_en) begin
            r_mul <= n_mul;
        end
    end

    assign w_div[0] = r_mul;

    for (genvar k = 0; k < Qb; k++) begin : g_div
        tvt_div_cell #(
            .QuoBit(Qb - 1 - k)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_stage(w_div[k]),
            .o_stage(w_div[k+1])
        );
    end

    always_comb begin
        n_out_temp = '0;
        if (w_div[Qb].found) begin
            if (w_div[Qb].zero_span) begin
                n_out_temp = w_div[Qb].base;
            end else begin
                n_out_temp = w_div[Qb].base + tvt_pkg::TempBits'(w_div[Qb].quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div[Qb].valid;
            r_out_temp  <= n_out_temp;
            r_out_oor   <= !w_div[Qb].found;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {1'b0, r_out_temp};
    assign o_m_axis_tuser[0] = r_out_oor;

    `TVT_ASSERT_IMPLY(a_found_in_span, i_clk, i_rst_n, w_srch[Segs].valid,
        w_srch[Segs].found == ((w_srch[Segs].voltage <= VFirst)
                               && (w_srch[Segs].voltage >= VLast)))
    `TVT_ASSERT_IMPLY(a_quo_bound, i_clk, i_rst_n,
        w_div[Qb].valid && w_div[Qb].found && !w_div[Qb].zero_span,
        w_div[Qb].quo <= Qb'(tvt_pkg::TempStep))
    `TVT_ASSERT_IMPLY(a_oor_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0],
        o_m_axis_tdata == '0)
    `TVT_ASSERT_NEXT(a_div_to_out, i_clk, i_rst_n, w_en && w_div[Qb].valid, o_m_axis_tvalid)

endmodule

// ----- hw/rtl/tvt_search_cell.sv -----
// segment search cell: claims the beat if its voltage lies in this cell's table segment and no earlier cell claimed it
module tvt_search_cell #(
    parameter int SegIdx = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  tvt_pkg::t_srch i_stage,
    output tvt_pkg::t_srch o_stage
);

    localparam logic [tvt_pkg::VoltBits-1:0] Vh = tvt_pkg::volt_point(SegIdx);
    localparam logic [tvt_pkg::VoltBits-1:0] Vl = tvt_pkg::volt_point(SegIdx + 1);
    localparam int BaseInt = tvt_pkg::TempStart + tvt_pkg::TempStep * SegIdx;
    localparam logic signed [tvt_pkg::TempBits-1:0] Base = tvt_pkg::TempBits'(BaseInt);

    tvt_pkg::t_srch r_stage;
    tvt_pkg::t_srch n_stage;
    logic           w_hit;

    assign w_hit = !i_stage.found && (i_stage.voltage <= Vh) && (i_stage.voltage >= Vl);

    always_comb begin
        n_stage = i_stage;
        if (w_hit) begin
            n_stage.found = 1'b1;
            n_stage.diff  = Vh - i_stage.voltage;
            n_stage.span  = Vh - Vl;
            n_stage.base  = Base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ----- hw/rtl/tvt_div_cell.sv -----
// restoring divider cell: resolves one quotient bit per beat
module tvt_div_cell #(
    parameter int QuoBit = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  tvt_pkg::t_div i_stage,
    output tvt_pkg::t_div o_stage
);

    tvt_pkg::t_div               r_stage;
    tvt_pkg::t_div               n_stage;
    logic [tvt_pkg::RemBits-1:0] w_sub;

    assign w_sub = tvt_pkg::RemBits'(i_stage.span) << QuoBit;

    always_comb begin
        n_stage = i_stage;
        if (i_stage.rem >= w_sub) begin
            n_stage.rem         = i_stage.rem - w_sub;
            n_stage.quo[QuoBit] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule
